[rtl/core/rc_pulse_to_duty_command_defines.svh]
// Assertion macros used by the top level of the RC pulse decoder RTL.
`ifndef RC_PULSE_TO_DUTY_COMMAND_DEFINES_SVH
`define RC_PULSE_TO_DUTY_COMMAND_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RCPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rcpd_pkg.sv]
// Shared widths, codes, reset values and control structs of the RC pulse decoder.
package rcpd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned WidthW   = 16;
  localparam int unsigned StoredW  = 12;
  localparam int unsigned MinW     = 11;
  localparam int unsigned MaxW     = 12;
  localparam int unsigned DutyW    = 17;
  localparam int unsigned TicksW   = 17;
  localparam int unsigned KindW    = 2;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DivSteps = FracBits + 1;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] RegInputEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxWidth    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStopDuty    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStartMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStartMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTimeout     = 3'd6;

  localparam logic OpPulse = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam logic [KindW-1:0] KindRun     = 2'd0;
  localparam logic [KindW-1:0] KindStop    = 2'd1;
  localparam logic [KindW-1:0] KindTimeout = 2'd2;

  localparam logic [WidthW-1:0] PulseMinUs = 16'd500;
  localparam logic [WidthW-1:0] PulseMaxUs = 16'd3000;

  localparam logic [MinW-1:0]   ResetMinWidth = 11'd1000;
  localparam logic [MaxW-1:0]   ResetMaxWidth = 12'd2000;
  localparam logic [DutyW-1:0]  ResetStopDuty = 17'd1966;
  localparam logic [DutyW-1:0]  ResetStartMin = 17'd3932;
  localparam logic [DutyW-1:0]  ResetStartMax = 17'd26214;
  localparam logic [TicksW-1:0] ResetTimeout  = 17'd65536;

  typedef struct packed {
    logic load_item;
    logic tick_update;
    logic div_init;
    logic div_step;
    logic emit;
  } rcpd_cmd_t;

  typedef struct packed {
    logic enable;
    logic is_tick;
    logic pulse_ok;
    logic tick_notice;
  } rcpd_sts_t;

endpackage

[rtl/core/rcpd_in_if.sv]
// Input channel of the RC pulse decoder: valid, ready and one item.
interface rcpd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [rcpd_pkg::WidthW-1:0]  pulse_width_us;
  logic                         motor_idle;

  modport source (output valid, operation, pulse_width_us, motor_idle, input ready);
  modport sink   (input valid, operation, pulse_width_us, motor_idle, output ready);
endinterface

[rtl/core/rcpd_out_if.sv]
// Output channel of the RC pulse decoder: valid, ready and one command.
interface rcpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rcpd_pkg::KindW-1:0]  command_kind;
  logic [rcpd_pkg::DutyW-1:0]  duty;

  modport source (output valid, command_kind, duty, input ready);
  modport sink   (input valid, command_kind, duty, output ready);
endinterface

[rtl/core/rcpd_dp.sv]
// Datapath: configuration, pulse and tick state, serial divider and result register.
module rcpd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          operation_i,
  input  logic [rcpd_pkg::WidthW-1:0]   pulse_width_us_i,
  input  logic                          motor_idle_i,
  input  rcpd_pkg::rcpd_cmd_t           cmd_i,
  output rcpd_pkg::rcpd_sts_t           sts_o,
  output logic [rcpd_pkg::KindW-1:0]    command_kind_o,
  output logic [rcpd_pkg::DutyW-1:0]    duty_o
);
  import rcpd_pkg::*;

  logic              enable_q;
  logic [MinW-1:0]   min_width_q;
  logic [MaxW-1:0]   max_width_q;
  logic [DutyW-1:0]  stop_duty_q;
  logic [DutyW-1:0]  start_min_q;
  logic [DutyW-1:0]  start_max_q;
  logic [TicksW-1:0] timeout_q;

  logic [StoredW-1:0] last_width_q;
  logic [TicksW-1:0]  idle_ticks_q;

  logic               op_q;
  logic [WidthW-1:0]  width_q;
  logic               idle_q;
  logic [StoredW:0]   rem_q;
  logic [StoredW-1:0] den_q;
  logic [DutyW-1:0]   quo_q;
  logic               empty_q;
  logic [KindW-1:0]   kind_q;
  logic [DutyW-1:0]   duty_q;

  logic [TicksW-1:0]  limit;
  logic [TicksW:0]    ticks_next;
  logic               expire;
  logic               notice;
  logic               pulse_ok;
  logic [StoredW-1:0] w12;
  logic [StoredW-1:0] lo12;
  logic [StoredW-1:0] clamped;
  logic [StoredW-1:0] num;
  logic [StoredW-1:0] den;
  logic               empty;
  logic               ge;
  logic [StoredW-1:0] diff;
  logic [DutyW-1:0]   duty;
  logic               stop;

  // Tick: count up and clear the stored width once the timeout is reached.
  assign limit      = (timeout_q == '0) ? TicksW'(1) : timeout_q;
  assign ticks_next = {1'b0, idle_ticks_q} + (TicksW+1)'(1);
  assign expire     = ticks_next >= {1'b0, limit};
  assign notice     = expire && (last_width_q != '0);

  assign pulse_ok = (width_q >= PulseMinUs) && (width_q <= PulseMaxUs);

  assign w12     = width_q[StoredW-1:0];
  assign lo12    = {1'b0, min_width_q};
  assign clamped = (w12 < lo12) ? lo12 : ((w12 > max_width_q) ? max_width_q : w12);
  assign num     = clamped - lo12;
  assign den     = max_width_q - lo12;
  assign empty   = max_width_q <= lo12;

  // One quotient bit a step; the first step yields the integer bit.
  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = ge ? (rem_q[StoredW-1:0] - den_q) : rem_q[StoredW-1:0];

  assign duty = empty_q ? '0 : quo_q;
  assign stop = (idle_q && ((duty < start_min_q) || (duty > start_max_q)))
                || (duty < stop_duty_q) || (duty == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      min_width_q  <= ResetMinWidth;
      max_width_q  <= ResetMaxWidth;
      stop_duty_q  <= ResetStopDuty;
      start_min_q  <= ResetStartMin;
      start_max_q  <= ResetStartMax;
      timeout_q    <= ResetTimeout;
      last_width_q <= '0;
      idle_ticks_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegInputEnable: enable_q    <= cfg_wdata_i[0];
          RegMinWidth:    min_width_q <= cfg_wdata_i[MinW-1:0];
          RegMaxWidth:    max_width_q <= cfg_wdata_i[MaxW-1:0];
          RegStopDuty:    stop_duty_q <= cfg_wdata_i[DutyW-1:0];
          RegStartMin:    start_min_q <= cfg_wdata_i[DutyW-1:0];
          RegStartMax:    start_max_q <= cfg_wdata_i[DutyW-1:0];
          RegTimeout:     timeout_q   <= cfg_wdata_i[TicksW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick_update) begin
        if (expire) begin
          last_width_q <= '0;
          idle_ticks_q <= '0;
        end else begin
          idle_ticks_q <= ticks_next[TicksW-1:0];
        end
      end
      if (cmd_i.div_init) begin
        last_width_q <= w12;
        idle_ticks_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= operation_i;
      width_q <= pulse_width_us_i;
      idle_q  <= motor_idle_i;
    end
    if (cmd_i.div_init) begin
      rem_q   <= {1'b0, num};
      den_q   <= den;
      quo_q   <= '0;
      empty_q <= empty;
    end
    if (cmd_i.div_step) begin
      rem_q <= {diff, 1'b0};
      quo_q <= {quo_q[DutyW-2:0], ge};
    end
    if (cmd_i.emit) begin
      if (op_q == OpTick) begin
        kind_q <= KindTimeout;
        duty_q <= '0;
      end else if (stop) begin
        kind_q <= KindStop;
        duty_q <= '0;
      end else begin
        kind_q <= KindRun;
        duty_q <= duty;
      end
    end
  end

  assign sts_o.enable      = enable_q;
  assign sts_o.is_tick     = op_q == OpTick;
  assign sts_o.pulse_ok    = pulse_ok;
  assign sts_o.tick_notice = notice;

  assign command_kind_o = kind_q;
  assign duty_o         = duty_q;

endmodule

[rtl/core/rcpd_ctrl.sv]
// Controller: sequences item capture, tick update, divider steps and result hand-off.
module rcpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rcpd_pkg::rcpd_sts_t sts_i,
  output rcpd_pkg::rcpd_cmd_t cmd_o
);
  import rcpd_pkg::*;

  typedef enum logic [1:0] {StIdle, StExec, StDiv, StEmit} state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [StepCntW-1:0] step_q;
  logic                out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: cmd_o.load_item = in_valid_i && sts_i.enable;
      StExec: begin
        cmd_o.tick_update = sts_i.is_tick;
        cmd_o.div_init    = !sts_i.is_tick && sts_i.pulse_ok;
      end
      StDiv:  cmd_o.div_step = 1'b1;
      StEmit: cmd_o.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      // A new result may replace the one taken in the same cycle.
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          // A beat taken while disabled is dropped here.
          if (in_valid_i && sts_i.enable) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (sts_i.is_tick) begin
            state_q <= sts_i.tick_notice ? StEmit : StIdle;
          end else if (sts_i.pulse_ok) begin
            state_q <= StDiv;
            step_q  <= '0;
          end else begin
            state_q <= StIdle;
          end
        end
        StDiv: begin
          if (step_q == StepCntW'(DivSteps - 1)) begin
            state_q <= StEmit;
          end else begin
            step_q <= step_q + StepCntW'(1);
          end
        end
        StEmit: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[rtl/core/rc_pulse_to_duty_command.sv]
// Top level of the RC pulse decoder that turns pulse widths and ticks into motor commands.
//
//  channel  dir  beat payload                                 handshake
//  in_i     in   operation, pulse_width_us, motor_idle        valid/ready
//  out_o    out  command_kind, duty                           valid/ready
//  cfg      in   cfg_index_i, cfg_wdata_i                     cfg_we_i, no wait
//
// A pulse goes from acceptance to a loaded result through the capture state, the set-up
// state, 17 steps of the restoring divider (one quotient bit each) and the emit state.
// A tick or rejected pulse ends after capture and set-up; a timeout notice also emits.
// Reset clears control, configuration, pulse and tick state at once (no clearing pass),
// not the item, divider or result registers. A result waits in the output register
// while the next beat is taken; the emit step holds only while that register stays full.
`include "rc_pulse_to_duty_command_defines.svh"

module rc_pulse_to_duty_command (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  rcpd_in_if.sink                       in_i,
  rcpd_out_if.source                    out_o
);
  import rcpd_pkg::*;

  rcpd_cmd_t cmd;
  rcpd_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  rcpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rcpd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (in_i.operation),
    .pulse_width_us_i (in_i.pulse_width_us),
    .motor_idle_i     (in_i.motor_idle),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_kind_o   (out_o.command_kind),
    .duty_o           (out_o.duty)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  `RCPD_ASSERT_NEXT(a_busy_after_beat, in_i.valid && in_i.ready && sts.enable, !in_i.ready, "block took a second beat while busy")
  `RCPD_ASSERT_NOW(a_quiet_duty, out_o.valid && (out_o.command_kind != KindRun), out_o.duty == '0, "stop or timeout carries a nonzero duty")
  `RCPD_ASSERT_NOW(a_run_duty, out_o.valid && (out_o.command_kind == KindRun), out_o.duty != '0, "run command with zero duty")
  `RCPD_ASSERT_NOW(a_emit_slot, cmd.emit, !out_valid || out_o.ready, "result loaded over an untaken beat")

endmodule

[sim/rc_pulse_to_duty_command_tb.sv]
// Self-checking testbench for the RC pulse decoder: directed table, random beats, scoreboard.
module rc_pulse_to_duty_command_tb;
  import rcpd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumDirected = 35;

  // Writes to this index must leave every register untouched.
  localparam logic [CfgIdxW-1:0] RegBeyondLast = 3'd7;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DutyW-1:0] duty;
  } command_t;

  typedef enum logic [1:0] {RowPulse, RowTick, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [WidthW-1:0]   width;
    logic                idle;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    logic                typed;
    logic                exp_valid;
    logic [KindW-1:0]    exp_kind;
    logic [DutyW-1:0]    exp_duty;
  } row_t;

  // Rows marked typed carry their own expectation; all rows still go through the decoder model.
  localparam row_t DirectedRows [NumDirected] = '{
    '{RowPulse, 16'd1500,  1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegInputEnable, 17'd1,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd2000,  1'b0, RegInputEnable, 17'd0,      1'b1, 1'b1, KindRun,  17'd65536},
    '{RowPulse, 16'd3000,  1'b0, RegInputEnable, 17'd0,      1'b1, 1'b1, KindRun,  17'd65536},
    '{RowPulse, 16'd3001,  1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd499,   1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd500,   1'b0, RegInputEnable, 17'd0,      1'b1, 1'b1, KindStop, 17'd0},
    '{RowPulse, 16'd65535, 1'b1, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd0,     1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd1500,  1'b1, RegInputEnable, 17'd0,      1'b1, 1'b1, KindStop, 17'd0},
    '{RowPulse, 16'd1200,  1'b1, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd1030,  1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd1029,  1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd1500,  1'b1, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegTimeout,     17'd2,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegTimeout,     17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd1500,  1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowTick,  16'd0,     1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegBeyondLast,  17'h1FFFF,  1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegMinWidth,    17'd2047,   1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd2500,  1'b0, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegMinWidth,    17'd800,    1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegMaxWidth,    17'd2200,   1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegStopDuty,    17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegStartMin,    17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegStartMax,    17'd65536,  1'b0, 1'b0, KindRun,  17'd0},
    '{RowWrite, 16'd0,     1'b0, RegTimeout,     17'h1FFFF,  1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd800,   1'b1, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd2200,  1'b1, RegInputEnable, 17'd0,      1'b0, 1'b0, KindRun,  17'd0},
    '{RowPulse, 16'd4095,  1'b0, RegInputEnable, 17'd0,      1'b1, 1'b0, KindRun,  17'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rcpd_in_if  in_ch ();
  rcpd_out_if out_ch ();

  rc_pulse_to_duty_command dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Register copies and decoder state of the model.
  logic               cfg_enable;
  logic [MinW-1:0]    cfg_min;
  logic [MaxW-1:0]    cfg_max;
  logic [DutyW-1:0]   cfg_stop;
  logic [DutyW-1:0]   cfg_start_min;
  logic [DutyW-1:0]   cfg_start_max;
  logic [TicksW-1:0]  cfg_timeout;
  logic [StoredW-1:0] stored_width;
  logic [TicksW-1:0]  idle_ticks;

  command_t    pending_cmds[$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          cfg_writing;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned settings_applied;
  int unsigned run_count;
  int unsigned stop_count;
  int unsigned notice_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [DutyW-1:0] width_to_duty(input logic [StoredW-1:0] w);
    longint unsigned pos;
    longint unsigned span;
    if (cfg_max <= cfg_min) return '0;
    pos = w;
    if (pos < cfg_min) pos = cfg_min;
    if (pos > cfg_max) pos = cfg_max;
    span = cfg_max - cfg_min;
    return DutyW'(((pos - cfg_min) << FracBits) / span);
  endfunction

  // Advances the decoder model by one beat; returns 1 when a command is due.
  function automatic bit decode_beat(input logic op, input logic [WidthW-1:0] w,
                                     input logic idle, output command_t cmd);
    logic [TicksW:0]   next_ticks;
    logic [TicksW-1:0] limit;
    logic [DutyW-1:0]  duty;
    bit                notice;
    bit                stop;
    cmd = '0;
    if (!cfg_enable) return 0;
    if (op == OpTick) begin
      limit      = (cfg_timeout == '0) ? TicksW'(1) : cfg_timeout;
      next_ticks = idle_ticks + 1'b1;
      if (next_ticks >= limit) begin
        notice       = (stored_width != '0);
        stored_width = '0;
        idle_ticks   = '0;
        cmd.kind     = KindTimeout;
        return notice;
      end
      idle_ticks = next_ticks[TicksW-1:0];
      return 0;
    end
    if (w < PulseMinUs || w > PulseMaxUs) return 0;
    stored_width = w[StoredW-1:0];
    idle_ticks   = '0;
    duty         = width_to_duty(stored_width);
    if (idle && (duty < cfg_start_min || duty > cfg_start_max)) stop = 1'b1;
    else stop = (duty < cfg_stop) || (duty == '0);
    cmd.kind = stop ? KindStop : KindRun;
    cmd.duty = stop ? '0 : duty;
    return 1;
  endfunction

  // Lowers valid and waits until the block has nothing left in flight.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic config_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    if (!cfg_writing) drain_block();
    case (idx)
      RegInputEnable: cfg_enable    = value[0];
      RegMinWidth:    cfg_min       = value[MinW-1:0];
      RegMaxWidth:    cfg_max       = value[MaxW-1:0];
      RegStopDuty:    cfg_stop      = value[DutyW-1:0];
      RegStartMin:    cfg_start_min = value[DutyW-1:0];
      RegStartMax:    cfg_start_max = value[DutyW-1:0];
      RegTimeout:     cfg_timeout   = value[TicksW-1:0];
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    cfg_writing = 1'b1;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic en, input logic [CfgDataW-1:0] min_w,
                                input logic [CfgDataW-1:0] max_w,
                                input logic [CfgDataW-1:0] stop,
                                input logic [CfgDataW-1:0] start_lo,
                                input logic [CfgDataW-1:0] start_hi,
                                input logic [CfgDataW-1:0] tmo);
    config_write(RegInputEnable, CfgDataW'(en));
    config_write(RegMinWidth, min_w);
    config_write(RegMaxWidth, max_w);
    config_write(RegStopDuty, stop);
    config_write(RegStartMin, start_lo);
    config_write(RegStartMax, start_hi);
    config_write(RegTimeout, tmo);
    settings_applied++;
  endtask

  // Drives one beat and records what it should produce once it is accepted.
  task automatic send_item(input logic op, input logic [WidthW-1:0] w, input logic idle,
                           input bit typed, input bit exp_valid, input command_t exp_cmd);
    command_t cmd;
    bit       has_cmd;
    if (cfg_writing) begin
      cfg_we_i <= 1'b0;
      cfg_writing = 1'b0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.pulse_width_us <= w;
    in_ch.motor_idle     <= idle;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    has_cmd = decode_beat(op, w, idle, cmd);
    if (typed) begin
      has_cmd = exp_valid;
      cmd     = exp_cmd;
    end
    if (has_cmd) pending_cmds.push_back(cmd);
    beats_sent++;
  endtask

  // Mostly well-formed pulses, some around the clamp window, plus ticks and rejects.
  task automatic random_items(input int unsigned count);
    int unsigned       pick;
    logic [WidthW-1:0] w;
    logic              op;
    repeat (count) begin
      pick = $urandom_range(99);
      op   = OpPulse;
      if (pick < 35) w = WidthW'($urandom_range(PulseMaxUs, PulseMinUs));
      else if (pick < 55) w = WidthW'($urandom_range(cfg_max + 60, cfg_min - 60));
      else if (pick < 60) w = WidthW'($urandom_range(PulseMinUs - 1));
      else if (pick < 65) w = WidthW'($urandom_range(65535, PulseMaxUs + 1));
      else begin
        op = OpTick;
        w  = WidthW'($urandom);
      end
      send_item(op, w, 1'($urandom_range(1)), 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d commands outstanding",
               cycle_count, pending_cmds.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: compare each accepted command with the oldest outstanding one.
  always @(posedge clk_i) begin
    command_t want;
    if (rst_ni === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        case (out_ch.command_kind)
          KindRun:     run_count++;
          KindStop:    stop_count++;
          KindTimeout: notice_count++;
          default: ;
        endcase
        if (pending_cmds.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("unexpected command: kind %0d duty %0d",
                     out_ch.command_kind, out_ch.duty);
        end else begin
          want = pending_cmds.pop_front();
          if (out_ch.command_kind !== want.kind || out_ch.duty !== want.duty) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("command mismatch: kind %0d duty %0d, expected kind %0d duty %0d",
                       out_ch.command_kind, out_ch.duty, want.kind, want.duty);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    row_t     row;
    command_t typed_cmd;
    int       chunk;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = RegInputEnable;
    cfg_wdata_i          = '0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OpPulse;
    in_ch.pulse_width_us = '0;
    in_ch.motor_idle     = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_enable           = 1'b0;
    cfg_min              = ResetMinWidth;
    cfg_max              = ResetMaxWidth;
    cfg_stop             = ResetStopDuty;
    cfg_start_min        = ResetStartMin;
    cfg_start_max        = ResetStartMax;
    cfg_timeout          = ResetTimeout;
    stored_width         = '0;
    idle_ticks           = '0;
    cfg_writing          = 1'b0;
    send_gap_pct         = 30;
    recv_stall_pct       = 56;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      if (row.kind == RowWrite) begin
        config_write(row.idx, row.value);
      end else begin
        typed_cmd.kind = row.exp_kind;
        typed_cmd.duty = row.exp_duty;
        send_item((row.kind == RowTick) ? OpTick : OpPulse, row.width, row.idle,
                  row.typed, row.exp_valid, typed_cmd);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct   = (mode == 0) ? 30 : ((mode == 1) ? 56 : 0);
      recv_stall_pct = (mode == 0) ? 56 : ((mode == 1) ? 30 : 0);
      for (int c = 0; c < 3; c++) begin
        chunk = mode * 3 + c;
        if (chunk == 5) begin
          // With the block disabled every beat must vanish without a trace.
          config_write(RegInputEnable, '0);
          random_items(15);
        end
        case (chunk)
          0: apply_settings(1'b1, 1000, 2000, 1966, 3932, 26214, 4);
          1: apply_settings(1'b1, 800, 2200, 0, 0, 65536, 1);
          2: apply_settings(1'b1, 1200, 1800, 65536, 65536, 0, 131071);
          default: apply_settings(1'b1, CfgDataW'($urandom_range(1200, 800)),
                                  CfgDataW'($urandom_range(2200, 1800)),
                                  CfgDataW'($urandom_range(6000)),
                                  CfgDataW'($urandom_range(12000)),
                                  CfgDataW'($urandom_range(65536, 16000)),
                                  CfgDataW'($urandom_range(12, 1)));
        endcase
        if (chunk == 4) begin
          random_items(20);
          drain_block();
          random_items(25);
        end else begin
          random_items(45);
        end
      end
    end

    drain_block();
    $display("sent %0d beats under %0d register settings plus the directed table",
             beats_sent, settings_applied);
    $display("checked %0d run, %0d stop and %0d timeout commands, %0d mismatches",
             run_count, stop_count, notice_count, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rcpd_pkg.sv
rtl/core/rcpd_in_if.sv
rtl/core/rcpd_out_if.sv
rtl/core/rcpd_dp.sv
rtl/core/rcpd_ctrl.sv
rtl/core/rc_pulse_to_duty_command.sv
sim/rc_pulse_to_duty_command_tb.sv
